>>> sv/first_fit_block_allocator_top_defines.svh
// Assertion macros shared by the first-fit allocator RTL.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ffba_pkg.sv
// Package for the first-fit block allocator: sizes, codes and the
// command and status structs between controller and datapath. No dependencies.
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 32;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int HND_W        = $clog2(MAX_BLOCKS + 1);

  localparam int OPC_W     = 2;
  localparam int SIZE_W    = 27;
  localparam int ADDR_W    = 32;
  localparam int STAT_W    = 2;
  localparam int HBYTE_W   = 12;
  localparam int PROD_W    = 2 * SIZE_W;
  localparam int SUM_W     = ADDR_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int RAM_W     = SIZE_W + ADDR_W;

  localparam logic [PROD_W-1:0] SIZE_LIMIT = PROD_W'(10 * 10 * 10 * 10 * 10 * 10 * 10 * 10);
  localparam logic [HND_W-1:0]  HANDLE_NONE = HND_W'(MAX_BLOCKS);
  localparam logic [ADDR_W-1:0] HEAP_CAP_RESET = ADDR_W'(1048576);

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_CAP  = CFG_IDX_W'(1);

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_CALLOC  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_NOROOM = 2'd2,
    ST_NOP    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_OLD,
    RES_HIT,
    RES_NEW
  } res_src_t;

  typedef struct packed {
    logic     load_in;
    logic     load_size;
    logic     load_old;
    logic     scan_start;
    logic     scan_step;
    logic     take_hit;
    logic     append;
    logic     free_old;
    logic     res_set;
    res_src_t res_src;
    status_t  res_status;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic size_bad;
    logic bh_none;
    logic bh_valid;
    logic old_free;
    logic old_fits;
    logic hit;
    logic scan_done;
    logic no_room;
  } dp_stat_t;

endpackage

>>> sv/ffba_in_if.sv
// Request channel of the first-fit block allocator.
// Depends on ffba_pkg for field widths.
interface ffba_in_if import ffba_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OPC_W-1:0]    opcode;
  logic [SIZE_W-1:0]   request_size;
  logic [SIZE_W-1:0]   item_count;
  logic [HND_W-1:0]    block_handle;

  modport source (output valid, opcode, request_size, item_count, block_handle,
                  input ready);
  modport sink   (input valid, opcode, request_size, item_count, block_handle,
                  output ready);
endinterface

>>> sv/ffba_out_if.sv
// Result channel of the first-fit block allocator.
// Depends on ffba_pkg for field widths.
interface ffba_out_if import ffba_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [HND_W-1:0]    result_handle;
  logic [ADDR_W-1:0]   data_address;
  logic [HND_W-1:0]    free_block_count;
  logic [ADDR_W-1:0]   free_byte_count;
  logic [HND_W-1:0]    allocated_block_count;
  logic [ADDR_W-1:0]   allocated_byte_count;
  logic [HBYTE_W-1:0]  header_byte_count;

  modport source (output valid, status, result_handle, data_address, free_block_count,
                         free_byte_count, allocated_block_count, allocated_byte_count,
                         header_byte_count,
                  input ready);
  modport sink   (input valid, status, result_handle, data_address, free_block_count,
                        free_byte_count, allocated_block_count, allocated_byte_count,
                        header_byte_count,
                  output ready);
endinterface

>>> sv/ffba_cfg_if.sv
// Configuration write channel of the first-fit block allocator.
// Depends on ffba_pkg for field widths.
interface ffba_cfg_if import ffba_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ffba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ffba_datapath.sv
// Datapath of the first-fit block allocator: block table, free marks,
// usage counters, configuration registers and result register.
// Depends on ffba_pkg and ffba_ram.
module ffba_datapath import ffba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [OPC_W-1:0]     in_opcode,
  input  logic [SIZE_W-1:0]    in_request_size,
  input  logic [SIZE_W-1:0]    in_item_count,
  input  logic [HND_W-1:0]     in_block_handle,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output logic [STAT_W-1:0]    out_status,
  output logic [HND_W-1:0]     out_result_handle,
  output logic [ADDR_W-1:0]    out_data_address,
  output logic [HND_W-1:0]     out_free_block_count,
  output logic [ADDR_W-1:0]    out_free_byte_count,
  output logic [HND_W-1:0]     out_allocated_block_count,
  output logic [ADDR_W-1:0]    out_allocated_byte_count,
  output logic [HBYTE_W-1:0]   out_header_byte_count
);

  op_t                 op_r;
  logic [SIZE_W-1:0]   rsz_r;
  logic [SIZE_W-1:0]   cnt_r;
  logic [HND_W-1:0]    bh_r;
  logic [PROD_W-1:0]   sz_r;
  logic [SIZE_W-1:0]   old_size_r;
  logic [HND_W-1:0]    scan_idx_r;
  logic [IDX_W-1:0]    chk_idx_r;
  logic                rd_pend_r;
  status_t             res_status_r;
  logic [HND_W-1:0]    res_handle_r;
  logic [ADDR_W-1:0]   res_addr_r;

  logic [ADDR_W-1:0]   heap_base_r;
  logic [ADDR_W-1:0]   heap_cap_r;
  logic [HND_W-1:0]    bt_r;
  logic [ADDR_W-1:0]   heap_used_r;
  logic [HND_W-1:0]    free_blocks_r;
  logic [ADDR_W-1:0]   free_bytes_r;
  logic [ADDR_W-1:0]   payload_r;
  logic [MAX_BLOCKS-1:0] free_r;

  logic [STAT_W-1:0]   o_status_r;
  logic [HND_W-1:0]    o_handle_r;
  logic [ADDR_W-1:0]   o_addr_r;
  logic [HND_W-1:0]    o_free_blocks_r;
  logic [ADDR_W-1:0]   o_free_bytes_r;
  logic [HND_W-1:0]    o_blocks_r;
  logic [ADDR_W-1:0]   o_payload_r;
  logic [HBYTE_W-1:0]  o_hdr_r;

  logic [IDX_W-1:0]    ram_raddr;
  logic [RAM_W-1:0]    ram_rdata;
  logic [SIZE_W-1:0]   rd_size;
  logic [ADDR_W-1:0]   rd_off;
  logic [SIZE_W-1:0]   sz_small;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    heap_need;
  logic                scan_more;
  logic [ADDR_W-1:0]   addr_off;
  logic [ADDR_W-1:0]   res_addr_sum;
  logic [IDX_W-1:0]    bh_idx;

  assign bh_idx    = bh_r[IDX_W-1:0];
  assign ram_raddr = cmd.scan_step ? scan_idx_r[IDX_W-1:0] : bh_idx;
  assign rd_size   = ram_rdata[RAM_W-1:ADDR_W];
  assign rd_off    = ram_rdata[ADDR_W-1:0];
  assign sz_small  = sz_r[SIZE_W-1:0];
  assign prod      = rsz_r * cnt_r;
  assign heap_need = {1'b0, heap_used_r} + SUM_W'(HEADER_BYTES) + SUM_W'(sz_small);
  assign scan_more = scan_idx_r < bt_r;
  assign addr_off  = (cmd.res_src == RES_NEW) ? heap_used_r : rd_off;
  assign res_addr_sum = heap_base_r + addr_off + ADDR_W'(HEADER_BYTES);

  ffba_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (bt_r[IDX_W-1:0]),
    .wdata ({sz_small, heap_used_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.op        = op_r;
    stat.size_bad  = (sz_r == '0) || (sz_r > SIZE_LIMIT);
    stat.bh_none   = bh_r >= HANDLE_NONE;
    stat.bh_valid  = (bh_r < HANDLE_NONE) && (bh_r < bt_r);
    stat.old_free  = free_r[bh_idx];
    stat.old_fits  = rd_size >= rsz_r;
    stat.hit       = rd_pend_r && free_r[chk_idx_r] && (rd_size >= sz_small);
    stat.scan_done = !rd_pend_r && !scan_more;
    stat.no_room   = (bt_r >= HANDLE_NONE) || (heap_need > {1'b0, heap_cap_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= '0;
      heap_cap_r    <= HEAP_CAP_RESET;
      bt_r          <= '0;
      heap_used_r   <= '0;
      free_blocks_r <= '0;
      free_bytes_r  <= '0;
      payload_r     <= '0;
      free_r        <= '0;
      rd_pend_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          heap_base_r <= cfg_data;
        end else begin
          heap_cap_r <= cfg_data;
        end
      end
      if (cmd.scan_start) begin
        rd_pend_r <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_pend_r <= scan_more && !stat.hit;
      end
      if (cmd.take_hit) begin
        free_r[chk_idx_r] <= 1'b0;
        free_blocks_r     <= free_blocks_r - HND_W'(1);
        free_bytes_r      <= free_bytes_r - ADDR_W'(rd_size);
      end
      if (cmd.append) begin
        free_r[bt_r[IDX_W-1:0]] <= 1'b0;
        heap_used_r <= heap_used_r + ADDR_W'(HEADER_BYTES) + ADDR_W'(sz_small);
        payload_r   <= payload_r + ADDR_W'(sz_small);
        bt_r        <= bt_r + HND_W'(1);
      end
      if (cmd.free_old && !free_r[bh_idx]) begin
        free_r[bh_idx] <= 1'b1;
        free_blocks_r  <= free_blocks_r + HND_W'(1);
        free_bytes_r   <= free_bytes_r + ADDR_W'(old_size_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= op_t'(in_opcode);
      rsz_r <= in_request_size;
      cnt_r <= in_item_count;
      bh_r  <= in_block_handle;
    end
    if (cmd.load_size) begin
      sz_r <= (op_r == OP_CALLOC) ? prod : PROD_W'(rsz_r);
    end
    if (cmd.load_old) begin
      old_size_r <= rd_size;
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step && scan_more && !stat.hit) begin
      scan_idx_r <= scan_idx_r + HND_W'(1);
      chk_idx_r  <= scan_idx_r[IDX_W-1:0];
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      unique case (cmd.res_src)
        RES_NONE: begin
          res_handle_r <= HANDLE_NONE;
          res_addr_r   <= '0;
        end
        RES_OLD: begin
          res_handle_r <= bh_r;
          res_addr_r   <= res_addr_sum;
        end
        RES_HIT: begin
          res_handle_r <= HND_W'(chk_idx_r);
          res_addr_r   <= res_addr_sum;
        end
        RES_NEW: begin
          res_handle_r <= bt_r;
          res_addr_r   <= res_addr_sum;
        end
        default: begin
          res_handle_r <= HANDLE_NONE;
          res_addr_r   <= '0;
        end
      endcase
    end
    if (cmd.load_out) begin
      o_status_r      <= res_status_r;
      o_handle_r      <= res_handle_r;
      o_addr_r        <= res_addr_r;
      o_free_blocks_r <= free_blocks_r;
      o_free_bytes_r  <= free_bytes_r;
      o_blocks_r      <= bt_r;
      o_payload_r     <= payload_r;
      o_hdr_r         <= HBYTE_W'(ADDR_W'(bt_r) * ADDR_W'(HEADER_BYTES));
    end
  end

  assign out_status                = o_status_r;
  assign out_result_handle         = o_handle_r;
  assign out_data_address          = o_addr_r;
  assign out_free_block_count      = o_free_blocks_r;
  assign out_free_byte_count       = o_free_bytes_r;
  assign out_allocated_block_count = o_blocks_r;
  assign out_allocated_byte_count  = o_payload_r;
  assign out_header_byte_count     = o_hdr_r;

endmodule

>>> sv/ffba_ctrl.sv
// Controller of the first-fit block allocator: sequences each request
// through the datapath and owns the handshakes. Depends on ffba_pkg.
module ffba_ctrl import ffba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_OLD,
    S_SCAN,
    S_TAIL,
    S_RELFREE,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   has_old;

  assign has_old  = (stat.op == OP_REALLOC) && !stat.bh_none;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.load_size = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        unique case (stat.op)
          OP_ALLOC, OP_CALLOC: begin
            if (stat.size_bad) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_REJECT;
              cmd.res_src    = RES_NONE;
              state_nxt      = S_FINISH;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_FREE: begin
            if (stat.bh_valid) begin
              state_nxt = S_OLD;
            end else begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOP;
              cmd.res_src    = RES_NONE;
              state_nxt      = S_FINISH;
            end
          end
          OP_REALLOC: begin
            priority if (stat.size_bad) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_REJECT;
              cmd.res_src    = RES_NONE;
              state_nxt      = S_FINISH;
            end else if (stat.bh_none) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end else if (!stat.bh_valid) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOP;
              cmd.res_src    = RES_NONE;
              state_nxt      = S_FINISH;
            end else begin
              state_nxt = S_OLD;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_OLD: begin
        cmd.load_old = 1'b1;
        if (stat.op == OP_FREE) begin
          state_nxt = S_RELFREE;
        end else if (stat.old_fits) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_src    = RES_OLD;
          state_nxt      = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (stat.hit) begin
          cmd.take_hit   = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_src    = RES_HIT;
          state_nxt      = has_old ? S_RELFREE : S_FINISH;
        end else if (stat.scan_done) begin
          state_nxt = S_TAIL;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_TAIL: begin
        cmd.res_set = 1'b1;
        if (stat.no_room) begin
          cmd.res_status = ST_NOROOM;
          cmd.res_src    = RES_NONE;
          state_nxt      = S_FINISH;
        end else begin
          cmd.append     = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_src    = RES_NEW;
          state_nxt      = has_old ? S_RELFREE : S_FINISH;
        end
      end
      S_RELFREE: begin
        cmd.free_old = 1'b1;
        if (stat.op == OP_FREE) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = stat.old_free ? ST_NOP : ST_OK;
          cmd.res_src    = RES_NONE;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/first_fit_block_allocator_top.sv
// First-fit block allocator: keeps a table of up to MAX_BLOCKS heap blocks and
// serves allocate, free, reallocate and count-by-size allocate requests, one item at
// a time. An item ends early when its size is rejected or its handle is bad, or
// when a reallocate keeps its block; a free reads its entry and then marks it free;
// other items run the first-fit search, which reads one table entry per cycle from
// the block RAM. Any item may also wait for the previous result to be taken. A
// finished result waits in the output register while the next item is already
// being worked on. The table needs no clearing pass after reset, and configuration
// writes are taken at any time.
// Depends on ffba_pkg, the channel interfaces, ffba_ctrl and ffba_datapath.
`include "first_fit_block_allocator_top_defines.svh"

module first_fit_block_allocator_top import ffba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ffba_in_if.sink    in_ch,
  ffba_out_if.source out_ch,
  ffba_cfg_if.sink   cfg_ch
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ch.ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  ffba_datapath u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (dp_cmd),
    .stat                      (dp_stat),
    .in_opcode                 (in_ch.opcode),
    .in_request_size           (in_ch.request_size),
    .in_item_count             (in_ch.item_count),
    .in_block_handle           (in_ch.block_handle),
    .cfg_we                    (cfg_ch.valid),
    .cfg_index                 (cfg_ch.index),
    .cfg_data                  (cfg_ch.data),
    .out_status                (out_ch.status),
    .out_result_handle         (out_ch.result_handle),
    .out_data_address          (out_ch.data_address),
    .out_free_block_count      (out_ch.free_block_count),
    .out_free_byte_count       (out_ch.free_byte_count),
    .out_allocated_block_count (out_ch.allocated_block_count),
    .out_allocated_byte_count  (out_ch.allocated_byte_count),
    .out_header_byte_count     (out_ch.header_byte_count)
  );

  `FFBA_ASSERT_IMPL(a_free_le_total, out_ch.valid, out_ch.free_block_count <= out_ch.allocated_block_count, "more free blocks than carved blocks")
  `FFBA_ASSERT_IMPL(a_out_slot_free, dp_cmd.load_out, !out_ch.valid || out_ch.ready, "result register overwritten before it was taken")
  `FFBA_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready, "item accepted while another is in progress")
  `FFBA_ASSERT_IMPL(a_header_bytes, out_ch.valid, out_ch.header_byte_count == HBYTE_W'(ADDR_W'(out_ch.allocated_block_count) * ADDR_W'(HEADER_BYTES)), "header bytes disagree with block count")

endmodule
